@@ hdl/rtctp_pkg.sv @@
// Shared types and constants for the RTC command port and timing-pulse timer.
// Used by rtctp_cmd, rtctp_timer and the top level; depends on nothing else.
`timescale 1ns / 1ps

package rtctp_pkg;

    localparam int CNT_W = 18;

    localparam logic [CNT_W-1:0] PRESCALE_RESET = 18'd244140;

    // Command codes, shared by the parallel (0-6) and serial (0-15) commands.
    localparam logic [3:0] CMD_HOLD       = 4'd0;
    localparam logic [3:0] CMD_SHIFT      = 4'd1;
    localparam logic [3:0] CMD_PERIOD_64  = 4'd4;
    localparam logic [3:0] CMD_PERIOD_16  = 4'd5;
    localparam logic [3:0] CMD_PERIOD_2   = 4'd6;
    localparam logic [3:0] CMD_PERIOD_1   = 4'd7;
    localparam logic [3:0] CMD_PERIOD_1S  = 4'd8;
    localparam logic [3:0] CMD_PERIOD_10S = 4'd9;
    localparam logic [3:0] CMD_PERIOD_30S = 4'd10;
    localparam logic [3:0] CMD_PERIOD_60S = 4'd11;
    localparam logic [3:0] CMD_RUN        = 4'd13;
    localparam logic [3:0] CMD_STOP       = 4'd14;
    localparam logic [3:0] CMD_TEST       = 4'd15;

    // Parallel command value that selects the serial command register.
    localparam logic [2:0] PCMD_SERIAL = 3'd7;

    localparam logic [CNT_W-1:0] TP_64  = 18'd64;
    localparam logic [CNT_W-1:0] TP_16  = 18'd16;
    localparam logic [CNT_W-1:0] TP_2   = 18'd2;
    localparam logic [CNT_W-1:0] TP_1   = 18'd1;
    localparam logic [CNT_W-1:0] TP_1S  = 18'd4096;
    localparam logic [CNT_W-1:0] TP_10S = 18'd40960;
    localparam logic [CNT_W-1:0] TP_30S = 18'd122880;
    localparam logic [CNT_W-1:0] TP_60S = 18'd245760;

    localparam logic FUNC_PORT_WRITE = 1'b0;
    localparam logic FUNC_BASE_TICK  = 1'b1;

    localparam int CFG_ADDR_W = 3;

    typedef struct packed {
        logic       func;
        logic [5:0] wr_value;
    } cmd_item_t;

    typedef struct packed {
        logic tp_pulse;
        logic timer_stopped;
        logic shift_hold;
        logic test_mode;
    } result_t;

    // Timer requests raised by an executed command.
    typedef struct packed {
        logic             load_period;
        logic [CNT_W-1:0] period;
        logic             run;
    } tmr_ctrl_t;

    typedef struct packed {
        logic stopped;
        logic hold;
        logic test;
    } status_t;

endpackage

@@ hdl/rtctp_cmd.sv @@
// Control-port decoder: shift-clock and strobe edge detection, serial command
// register, command execution and mode flags. Depends on rtctp_pkg.
`timescale 1ns / 1ps

module rtctp_cmd
    import rtctp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      advance,
    input  cmd_item_t item,
    output tmr_ctrl_t ctrl,
    output status_t   status
);

    logic       clock_prev_reg, clock_prev_next;
    logic       strobe_prev_reg, strobe_prev_next;
    logic [3:0] serial_cmd_reg, serial_cmd_next;
    logic       hold_reg, hold_next;
    logic       stop_reg, stop_next;
    logic       test_reg, test_next;

    logic [2:0] pcmd;
    logic       strobe;
    logic       sclk;
    logic       din;
    logic [3:0] code;

    assign pcmd   = item.wr_value[2:0];
    assign strobe = item.wr_value[3];
    assign sclk   = item.wr_value[4];
    assign din    = item.wr_value[5];

    always_comb
    begin
        clock_prev_next  = clock_prev_reg;
        strobe_prev_next = strobe_prev_reg;
        serial_cmd_next  = serial_cmd_reg;
        hold_next        = hold_reg;
        stop_next        = stop_reg;
        test_next        = test_reg;
        ctrl             = '0;
        code             = {1'b0, pcmd};

        if (item.func == FUNC_PORT_WRITE)
        begin
            // The shift edge comes first, so a serial command can use the bit
            // written together with its strobe.
            if (clock_prev_reg && !sclk)
            begin
                serial_cmd_next = {din, serial_cmd_reg[3:1]};
            end
            clock_prev_next  = sclk;
            strobe_prev_next = strobe;

            if (pcmd == PCMD_SERIAL)
            begin
                code = serial_cmd_next;
            end

            if (strobe_prev_reg && !strobe)
            begin
                if (pcmd != PCMD_SERIAL)
                begin
                    test_next = 1'b0;
                end
                case (code)
                    CMD_HOLD:       hold_next = 1'b1;
                    CMD_SHIFT:      hold_next = 1'b0;
                    CMD_PERIOD_64:  begin ctrl.load_period = 1'b1; ctrl.period = TP_64;  end
                    CMD_PERIOD_16:  begin ctrl.load_period = 1'b1; ctrl.period = TP_16;  end
                    CMD_PERIOD_2:   begin ctrl.load_period = 1'b1; ctrl.period = TP_2;   end
                    CMD_PERIOD_1:   begin ctrl.load_period = 1'b1; ctrl.period = TP_1;   end
                    CMD_PERIOD_1S:  begin ctrl.load_period = 1'b1; ctrl.period = TP_1S;  end
                    CMD_PERIOD_10S: begin ctrl.load_period = 1'b1; ctrl.period = TP_10S; end
                    CMD_PERIOD_30S: begin ctrl.load_period = 1'b1; ctrl.period = TP_30S; end
                    CMD_PERIOD_60S: begin ctrl.load_period = 1'b1; ctrl.period = TP_60S; end
                    CMD_RUN:
                    begin
                        stop_next = 1'b0;
                        ctrl.run  = 1'b1;
                    end
                    CMD_STOP:       stop_next = 1'b1;
                    CMD_TEST:       test_next = 1'b1;
                    default:        ;
                endcase
            end
        end
    end

    always_comb
    begin
        status.stopped = stop_next;
        status.hold    = hold_next;
        status.test    = test_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_prev_reg  <= 1'b0;
            strobe_prev_reg <= 1'b0;
            serial_cmd_reg  <= '0;
            hold_reg        <= 1'b1;
            stop_reg        <= 1'b1;
            test_reg        <= 1'b0;
        end
        else if (advance)
        begin
            clock_prev_reg  <= clock_prev_next;
            strobe_prev_reg <= strobe_prev_next;
            serial_cmd_reg  <= serial_cmd_next;
            hold_reg        <= hold_next;
            stop_reg        <= stop_next;
            test_reg        <= test_next;
        end
    end

endmodule

@@ hdl/rtctp_timer.sv @@
// Prescaler and timing-pulse down counter driven by base clock tick items.
// Depends on rtctp_pkg.
`timescale 1ns / 1ps

module rtctp_timer
    import rtctp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic             tick,
    input  logic             stopped,
    input  tmr_ctrl_t        ctrl,
    input  logic [CNT_W-1:0] prescale_period,
    output logic             pulse
);

    logic [CNT_W-1:0] prescale_count_reg, prescale_count_next;
    logic [CNT_W-1:0] pulse_period_reg, pulse_period_next;
    logic [CNT_W-1:0] pulse_count_reg, pulse_count_next;
    logic [CNT_W-1:0] prescale_load;

    // A zero prescale period behaves as one.
    assign prescale_load = (prescale_period == '0) ? TP_1 : prescale_period;

    always_comb
    begin
        prescale_count_next = prescale_count_reg;
        pulse_period_next   = pulse_period_reg;
        pulse_count_next    = pulse_count_reg;
        pulse               = 1'b0;

        if (tick)
        begin
            if (prescale_count_reg > TP_1)
            begin
                prescale_count_next = prescale_count_reg - TP_1;
            end
            else
            begin
                prescale_count_next = prescale_load;
                if (!stopped)
                begin
                    if (pulse_count_reg <= TP_1)
                    begin
                        pulse_count_next = pulse_period_reg;
                        pulse            = 1'b1;
                    end
                    else
                    begin
                        pulse_count_next = pulse_count_reg - TP_1;
                    end
                end
            end
        end
        else if (ctrl.load_period)
        begin
            pulse_period_next   = ctrl.period;
            pulse_count_next    = ctrl.period;
            prescale_count_next = prescale_load;
        end
        else if (ctrl.run)
        begin
            pulse_count_next    = pulse_period_reg;
            prescale_count_next = prescale_load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_count_reg <= PRESCALE_RESET;
            pulse_period_reg   <= '0;
            pulse_count_reg    <= '0;
        end
        else if (advance)
        begin
            prescale_count_reg <= prescale_count_next;
            pulse_period_reg   <= pulse_period_next;
            pulse_count_reg    <= pulse_count_next;
        end
    end

endmodule

@@ hdl/rtc_command_port_and_tp_timer_core.sv @@
// Top level of the RTC command port and timing-pulse timer.
// Instantiates rtctp_cmd and rtctp_timer; depends on rtctp_pkg.
`timescale 1ns / 1ps

// Each item is either a control-port write or one base clock tick, and each
// item gives exactly one result carrying the pulse flag and the mode flags
// after that item. The block takes one item per clock cycle while no waiting
// result is stalled at the output; an item is held in an input register,
// processed in a single pass through the command decoder and the
// prescaler/pulse counter, and its result is loaded into the result register
// together with the per-item state update (edge flags, serial command,
// prescaler and pulse count), which sets the one-item-per-cycle rate. The
// prescale period is written over the APB port at address 0; the user must
// write it only while the block is idle, which the block does not enforce.

module rtc_command_port_and_tp_timer_core
    import rtctp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cmd_valid,
    output logic                  cmd_stall,
    input  cmd_item_t             cmd_data,

    output logic                  res_valid,
    input  logic                  res_stall,
    output result_t               res_data,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic             stage_valid_reg;
    cmd_item_t        stage_item_reg;
    logic             res_valid_reg;
    result_t          res_data_reg;
    logic [CNT_W-1:0] prescale_period_reg;

    logic             out_free;
    logic             advance;
    logic             stage_load;
    logic             cfg_sel;
    tmr_ctrl_t        ctrl;
    status_t          status;
    logic             pulse;

    assign out_free   = !res_valid_reg || !res_stall;
    assign advance    = stage_valid_reg && out_free;
    assign cmd_stall  = stage_valid_reg && !out_free;
    assign stage_load = cmd_valid && !cmd_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (!stage_valid_reg || advance)
        begin
            stage_valid_reg <= cmd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_load)
        begin
            stage_item_reg <= cmd_data;
        end
    end

    rtctp_cmd u_cmd (
        .clk    (clk),
        .rst_n  (rst_n),
        .advance(advance),
        .item   (stage_item_reg),
        .ctrl   (ctrl),
        .status (status)
    );

    rtctp_timer u_timer (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .tick           (stage_item_reg.func == FUNC_BASE_TICK),
        .stopped        (status.stopped),
        .ctrl           (ctrl),
        .prescale_period(prescale_period_reg),
        .pulse          (pulse)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            res_valid_reg <= stage_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_data_reg.tp_pulse      <= pulse;
            res_data_reg.timer_stopped <= status.stopped;
            res_data_reg.shift_hold    <= status.hold;
            res_data_reg.test_mode     <= status.test;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    // Only the first register slot decodes; the low address bits are ignored.
    assign cfg_sel = (paddr[CFG_ADDR_W-1] == 1'b0);
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_period_reg <= PRESCALE_RESET;
        end
        else if (psel && penable && pwrite && cfg_sel)
        begin
            prescale_period_reg <= pwdata[CNT_W-1:0];
        end
    end

    assign prdata = cfg_sel ? {{(32-CNT_W){1'b0}}, prescale_period_reg} : 32'd0;

endmodule

@@ sim/tb.sv @@
// Testbench for rtc_command_port_and_tp_timer_core: directed and random command
// and tick traffic, checked against an in-bench model. Depends on rtctp_pkg.
`timescale 1ns / 1ps

module tb;
    import rtctp_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] PRESCALE_ADDR = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] UNMAPPED_ADDR = 3'd4;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS = 10;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cmd_valid = 1'b0;
    logic                  cmd_stall;
    cmd_item_t             cmd_data = '0;
    logic                  res_valid;
    logic                  res_stall = 1'b0;
    result_t               res_data;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    rtc_command_port_and_tp_timer_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_data  (cmd_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Mirror of the block state, kept in step with accepted items.
    logic [CNT_W-1:0] pre_cfg = PRESCALE_RESET;
    logic [CNT_W-1:0] pre_count = PRESCALE_RESET;
    logic [CNT_W-1:0] tp_period = '0;
    logic [CNT_W-1:0] tp_count = '0;
    logic [3:0]       ser_cmd = '0;
    logic             sclk_last = 1'b0;
    logic             strobe_last = 1'b0;
    logic             hold_q = 1'b1;
    logic             stop_q = 1'b1;
    logic             test_q = 1'b0;

    result_t expected_flags[$];
    int      items_sent = 0;
    int      results_seen = 0;
    int      pulses_expected = 0;
    int      error_count = 0;
    int      settings_used = 1;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;

    task automatic note_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("ERROR: %s", msg);
    endtask

    function automatic logic [CNT_W-1:0] prescale_reload();
        return (pre_cfg == '0) ? CNT_W'(1) : pre_cfg;
    endfunction

    function automatic void load_tp_period(input logic [CNT_W-1:0] p);
        tp_period = p;
        tp_count  = p;
        pre_count = prescale_reload();
    endfunction

    function automatic void run_command(input logic [3:0] code);
        case (code)
            CMD_HOLD:       hold_q = 1'b1;
            CMD_SHIFT:      hold_q = 1'b0;
            CMD_PERIOD_64:  load_tp_period(TP_64);
            CMD_PERIOD_16:  load_tp_period(TP_16);
            CMD_PERIOD_2:   load_tp_period(TP_2);
            CMD_PERIOD_1:   load_tp_period(TP_1);
            CMD_PERIOD_1S:  load_tp_period(TP_1S);
            CMD_PERIOD_10S: load_tp_period(TP_10S);
            CMD_PERIOD_30S: load_tp_period(TP_30S);
            CMD_PERIOD_60S: load_tp_period(TP_60S);
            CMD_RUN:
            begin
                stop_q    = 1'b0;
                tp_count  = tp_period;
                pre_count = prescale_reload();
            end
            CMD_STOP:       stop_q = 1'b1;
            CMD_TEST:       test_q = 1'b1;
            default:        ;
        endcase
    endfunction

    function automatic logic base_tick();
        if (pre_count > CNT_W'(1))
        begin
            pre_count = pre_count - CNT_W'(1);
            return 1'b0;
        end
        pre_count = prescale_reload();
        // A stopped timer still takes the 4096 Hz tick but holds its count.
        if (stop_q)
            return 1'b0;
        if (tp_count <= CNT_W'(1))
        begin
            tp_count = tp_period;
            return 1'b1;
        end
        tp_count = tp_count - CNT_W'(1);
        return 1'b0;
    endfunction

    function automatic result_t rtc_next_result(input cmd_item_t it);
        result_t r;
        logic [2:0] pcmd;
        logic strobe, sclk, din;
        r.tp_pulse = 1'b0;
        if (it.func == FUNC_BASE_TICK)
            r.tp_pulse = base_tick();
        else
        begin
            {din, sclk, strobe, pcmd} = it.wr_value;
            // The shift-clock edge goes first, so a strobe in the same write
            // sees the newly shifted bit.
            if (sclk_last && !sclk)
                ser_cmd = {din, ser_cmd[3:1]};
            sclk_last = sclk;
            if (strobe_last && !strobe)
            begin
                if (pcmd == PCMD_SERIAL)
                    run_command(ser_cmd);
                else
                begin
                    test_q = 1'b0;
                    run_command({1'b0, pcmd});
                end
            end
            strobe_last = strobe;
        end
        r.timer_stopped = stop_q;
        r.shift_hold    = hold_q;
        r.test_mode     = test_q;
        return r;
    endfunction

    // Sends one item; valid stays high afterwards unless the next call idles.
    task automatic send_item(input cmd_item_t it);
        result_t r;
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_data  <= it;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        r = rtc_next_result(it);
        if (r.tp_pulse)
            pulses_expected++;
        expected_flags.push_back(r);
        items_sent++;
    endtask

    task automatic send_port(input logic [2:0] pcmd, input logic strobe,
                             input logic sclk, input logic din);
        cmd_item_t it;
        it.func     = FUNC_PORT_WRITE;
        it.wr_value = {din, sclk, strobe, pcmd};
        send_item(it);
    endtask

    task automatic send_tick();
        cmd_item_t it;
        it.func     = FUNC_BASE_TICK;
        it.wr_value = 6'($urandom);
        send_item(it);
    endtask

    task automatic send_parallel(input logic [2:0] pcmd);
        send_port(pcmd, 1'b1, 1'b0, 1'($urandom));
        send_port(pcmd, 1'b0, 1'b0, 1'($urandom));
    endtask

    // Shifts the code in LSB first, then strobes with the serial selector.
    // With merge set, the last shift-clock fall and the strobe fall share one write.
    task automatic send_serial(input logic [3:0] code, input bit merge, input int tick_pct);
        int i;
        for (i = 0; i < 4; i++)
        begin
            if ($urandom_range(99) < tick_pct)
                send_tick();
            if (merge && i == 3)
            begin
                send_port(PCMD_SERIAL, 1'b1, 1'b1, code[i]);
                send_port(PCMD_SERIAL, 1'b0, 1'b0, code[i]);
            end
            else
            begin
                send_port(3'($urandom), 1'b0, 1'b1, code[i]);
                send_port(3'($urandom), 1'b0, 1'b0, code[i]);
            end
        end
        if (!merge)
        begin
            send_port(PCMD_SERIAL, 1'b1, 1'b0, 1'($urandom));
            send_port(PCMD_SERIAL, 1'b0, 1'b0, 1'($urandom));
        end
    endtask

    task automatic drain();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (expected_flags.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] wdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (addr == PRESCALE_ADDR)
            pre_cfg = wdata[CNT_W-1:0];
    endtask

    task automatic apb_read_check(input logic [CFG_ADDR_W-1:0] addr);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[CNT_W-1:0] !== pre_cfg)
            note_error($sformatf("prescale readback: expected %0d, got %0d",
                                 pre_cfg, prdata[CNT_W-1:0]));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_prescale(input logic [CNT_W-1:0] value);
        logic [31:0] wdata;
        wdata = $urandom;
        wdata[CNT_W-1:0] = value;
        drain();
        apb_write(PRESCALE_ADDR, wdata);
        apb_read_check(PRESCALE_ADDR);
        settings_used++;
    endtask

    task automatic check_bit(input string fname, input logic want, input logic got);
        if (got !== want)
            note_error($sformatf("result %0d, %s: expected %0b, got %0b",
                                 results_seen, fname, want, got));
    endtask

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            results_seen++;
            if (expected_flags.size() == 0)
                note_error($sformatf("result %0d arrived with no item pending",
                                     results_seen));
            else
            begin
                want = expected_flags.pop_front();
                check_bit("tp_pulse", want.tp_pulse, res_data.tp_pulse);
                check_bit("timer_stopped", want.timer_stopped, res_data.timer_stopped);
                check_bit("shift_hold", want.shift_hold, res_data.shift_hold);
                check_bit("test_mode", want.test_mode, res_data.test_mode);
            end
        end
        res_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Register default and flags straight out of reset.
    task automatic test_reset_state();
        apb_read_check(PRESCALE_ADDR);
        send_tick();
        send_port(3'd0, 1'b0, 1'b0, 1'b0);
        send_tick();
        send_tick();
    endtask

    task automatic test_directed_commands();
        int i;
        set_prescale('0);
        // Run while the period is still zero: a pulse on every timer tick.
        send_serial(CMD_RUN, 1'b1, 0);
        send_tick();
        send_tick();
        for (i = 0; i < 7; i++)
            send_parallel(3'(i));
        send_tick();
        send_tick();
    endtask

    task automatic test_unmapped_write();
        drain();
        apb_write(UNMAPPED_ADDR, $urandom);
        apb_read_check(PRESCALE_ADDR);
    endtask

    task automatic test_random_traffic(input logic [CNT_W-1:0] prescale, input int n_items);
        int start;
        int pick;
        int n;
        int i;
        logic [3:0] code;
        set_prescale(prescale);
        start = items_sent;
        while (items_sent - start < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                if ($urandom_range(3) == 0)
                begin
                    case ($urandom_range(4))
                        0: code = CMD_RUN;
                        1: code = CMD_PERIOD_1;
                        2: code = CMD_PERIOD_2;
                        3: code = CMD_PERIOD_16;
                        default: code = CMD_PERIOD_64;
                    endcase
                end
                else
                    code = 4'($urandom);
                if (code < 4'd7 && $urandom_range(1) == 0)
                    send_parallel(code[2:0]);
                else
                    send_serial(code, 1'($urandom), 15);
            end
            else if (pick < 85)
            begin
                n = $urandom_range(20, 1);
                for (i = 0; i < n; i++)
                    send_tick();
            end
            else
            begin
                // Noise: raw port values and ticks in any mix.
                n = $urandom_range(4, 1);
                for (i = 0; i < n; i++)
                begin
                    if ($urandom_range(1) == 0)
                        send_tick();
                    else
                        send_port(3'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
                end
            end
        end
    endtask

    initial
    begin
        send_idle_pct = 25;
        recv_idle_pct = 77;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_directed_commands();
        test_random_traffic(18'd1, 450);
        test_unmapped_write();
        test_random_traffic(18'd262143, 120);

        send_idle_pct = 77;
        recv_idle_pct = 25;
        test_random_traffic(18'd0, 400);
        test_random_traffic(18'd3, 200);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(18'd2, 450);
        test_random_traffic(18'd7, 230);

        drain();
        if (expected_flags.size() != 0)
            note_error($sformatf("%0d results never arrived", expected_flags.size()));
        $display("Ran %0d items (%0d results, %0d timing pulses) over %0d prescale settings.",
                 items_sent, results_seen, pulses_expected, settings_used);
        $display("Errors found: %0d", error_count);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
